### sv/pbg_pkg.sv
// shared types and constants of the prior box generator
package pbg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE   = 3'd7;

  localparam logic [1:0] FUNC_MIN_SQUARE  = 2'd0;
  localparam logic [1:0] FUNC_MEAN_SQUARE = 2'd1;
  localparam logic [1:0] FUNC_ASPECT      = 2'd2;
  localparam logic [1:0] FUNC_UNUSED      = 2'd3;

  localparam logic [23:0] AR_UNIT = 24'd65536;

  localparam int unsigned COORD_W = 20;

  // geometry of the arithmetic units
  localparam int unsigned SQRT_W = 58;
  localparam int unsigned SQRT_K = 4;
  localparam int unsigned TDIV_N = 54;
  localparam int unsigned TDIV_D = 30;
  localparam int unsigned TDIV_K = 4;
  localparam int unsigned DIV_N  = 59;
  localparam int unsigned DIV_D  = 13;
  localparam int unsigned DIV_K  = 8;

  typedef struct packed {
    logic [9:0]  cell_col;
    logic [9:0]  cell_row;
    logic [1:0]  func;
    logic [12:0] base_px;
    logic [12:0] outer_px;
    logic [23:0] ratio_wh;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_xmin;
    logic signed [COORD_W-1:0] box_ymin;
    logic signed [COORD_W-1:0] box_xmax;
    logic signed [COORD_W-1:0] box_ymax;
    logic                      range_saturated;
  } out_t;

endpackage

### sv/pbg_div.sv
// pipelined restoring divider, K quotient bits per stage
module pbg_div #(
  parameter int unsigned N = 59,
  parameter int unsigned D = 13,
  parameter int unsigned K = 8
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [N-1:0] num_i,
  input  logic [D-1:0] den_i,
  output logic [N-1:0] quo_o
);

  localparam int unsigned NS = (N + K - 1) / K;
  localparam int unsigned NP = NS * K;

  logic [NP-1:0] q_q   [NS];
  logic [D-1:0]  r_q   [NS];
  logic [D-1:0]  den_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [NP-1:0] q_in, q_d;
    logic [D-1:0]  r_in, r_d, den_in;

    if (g == 0) begin : g_first
      assign q_in   = NP'(num_i);
      assign r_in   = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign q_in   = q_q[g-1];
      assign r_in   = r_q[g-1];
      assign den_in = den_q[g-1];
    end

    always_comb begin
      logic [D:0] w;
      logic       ge;
      q_d = q_in;
      r_d = r_in;
      for (int j = 0; j < K; j++) begin
        w  = {r_d, q_d[NP-1]};
        ge = (w >= {1'b0, den_in});
        r_d = ge ? D'(w - {1'b0, den_in}) : w[D-1:0];
        q_d = {q_d[NP-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[g]   <= q_d;
        r_q[g]   <= r_d;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = q_q[NS-1][N-1:0];

endmodule

### sv/pbg_sqrt.sv
// pipelined digit-by-digit square root, rounded to nearest
module pbg_sqrt #(
  parameter int unsigned W = 58,
  parameter int unsigned K = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] rad_i,
  output logic [W/2:0] root_o
);

  localparam int unsigned IT = W / 2;
  localparam int unsigned NS = (IT + K - 1) / K;
  localparam int unsigned XW = 2 * NS * K;

  logic [XW-1:0] x_q [NS];
  logic [IT-1:0] q_q [NS];
  logic [IT+1:0] r_q [NS];
  logic [IT:0]   root_q;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [XW-1:0] x_in, x_d;
    logic [IT-1:0] q_in, q_d;
    logic [IT+1:0] r_in, r_d;

    if (g == 0) begin : g_first
      assign x_in = XW'(rad_i);
      assign q_in = '0;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[g-1];
      assign q_in = q_q[g-1];
      assign r_in = r_q[g-1];
    end

    always_comb begin
      logic [IT+3:0] w;
      logic [IT+3:0] trial;
      x_d = x_in;
      q_d = q_in;
      r_d = r_in;
      for (int j = 0; j < K; j++) begin
        w     = {r_d, x_d[XW-1 -: 2]};
        trial = {2'b00, q_d, 2'b01};
        if (w >= trial) begin
          r_d = (IT+2)'(w - trial);
          q_d = {q_d[IT-2:0], 1'b1};
        end else begin
          r_d = w[IT+1:0];
          q_d = {q_d[IT-2:0], 1'b0};
        end
        x_d = {x_d[XW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g] <= x_d;
        q_q[g] <= q_d;
        r_q[g] <= r_d;
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (r_q[NS-1] > (IT+2)'(q_q[NS-1])) begin
        root_q <= (IT+1)'(q_q[NS-1]) + (IT+1)'(1);
      end else begin
        root_q <= (IT+1)'(q_q[NS-1]);
      end
    end
  end

  assign root_o = root_q;

endmodule

### sv/pbg_dly.sv
// stallable delay line for side data
module pbg_dly #(
  parameter int unsigned W   = 8,
  parameter int unsigned LEN = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] stg_q [LEN];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= d_i;
      for (int i = 1; i < LEN; i++) begin
        stg_q[i] <= stg_q[i-1];
      end
    end
  end

  assign q_o = stg_q[LEN-1];

endmodule

### sv/prior_box_generator_top.sv
// top level of the ssd prior box generator pipeline
//
//  channel   direction  handshake                   payload
//  cfg       in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
//  in        in         in_valid_i / in_ready_o     in_i  (pbg_pkg::in_t)
//  out       out        out_valid_o / out_ready_i   out_o (pbg_pkg::out_t)
//
//  one beat per cycle sustained while the output does not stall; the path runs through
//  the sqrt pipe, then the divide by the root, then the four normalizing dividers
//  beats of unused kind or unit aspect ratio are dropped after the input stage
//  reset clears the valid line and loads the register defaults
//  a stall at the output freezes the whole pipe; in_ready_o follows it
module prior_box_generator_top #(
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pbg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pbg_pkg::in_t                      in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pbg_pkg::out_t                     out_o
);

  localparam int unsigned COORD_W = pbg_pkg::COORD_W;

  // unit latencies
  localparam int unsigned LS = (pbg_pkg::SQRT_W / 2 + pbg_pkg::SQRT_K - 1) / pbg_pkg::SQRT_K + 1;
  localparam int unsigned LT = (pbg_pkg::TDIV_N + pbg_pkg::TDIV_K - 1) / pbg_pkg::TDIV_K;
  localparam int unsigned LD = (pbg_pkg::DIV_N + pbg_pkg::DIV_K - 1) / pbg_pkg::DIV_K;

  // stage positions of the valid line
  localparam int unsigned ST_RM  = LS + 2;
  localparam int unsigned ST_RP  = ST_RM + LT;
  localparam int unsigned ST_RH  = ST_RP + 1;
  localparam int unsigned ST_F1  = ST_RH + LD + 1;
  localparam int unsigned ST_OUT = ST_F1 + 1;
  localparam int unsigned NV     = ST_OUT + 1;

  localparam int unsigned ROOT_W = pbg_pkg::SQRT_W / 2 + 1;
  localparam int unsigned MNR_W  = 13 + ROOT_W;
  localparam int unsigned QW     = pbg_pkg::DIV_N;
  localparam int unsigned SUM_W  = QW + 2;
  localparam int unsigned SH     = 32 - OUT_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] ONE      = SUM_W'(1) << 32;
  localparam logic [SUM_W-1:0]        RND_HALF = SUM_W'(1) << (SH - 1);
  localparam logic [SUM_W-1:0]        POS_MAX  = (SUM_W'(1) << (COORD_W - 1)) - SUM_W'(1);
  localparam logic [SUM_W-1:0]        NEG_MAG  = SUM_W'(1) << (COORD_W - 1);
  localparam logic [COORD_W-1:0]      SAT_HI   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0]      SAT_LO   = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [1:0]  func;
    logic [12:0] mn;
  } sb_t;

  // config registers
  logic [12:0] img_w_q, img_h_q;
  logic [10:0] lay_w_q, lay_h_q;
  logic [23:0] step_x_q, step_y_q;
  logic [7:0]  off_q;
  logic        clip_q;

  // valid line and global advance
  logic [NV-1:0] v_q;
  logic          en;
  logic          keep;

  // stage 0 input register
  pbg_pkg::in_t  in_q;

  assign en          = !v_q[ST_OUT] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[ST_OUT];

  // drop unused kind and the unit aspect ratio (same box as the min square)
  assign keep = !(in_q.func == pbg_pkg::FUNC_UNUSED ||
                  (in_q.func == pbg_pkg::FUNC_ASPECT && in_q.ratio_wh == pbg_pkg::AR_UNIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= 13'd300;
      img_h_q  <= 13'd300;
      lay_w_q  <= 11'd38;
      lay_h_q  <= 11'd38;
      step_x_q <= '0;
      step_y_q <= '0;
      off_q    <= 8'd128;
      clip_q   <= 1'b0;
      v_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pbg_pkg::CFG_IMAGE_WIDTH:   img_w_q  <= cfg_wdata_i[12:0];
          pbg_pkg::CFG_IMAGE_HEIGHT:  img_h_q  <= cfg_wdata_i[12:0];
          pbg_pkg::CFG_LAYER_WIDTH:   lay_w_q  <= cfg_wdata_i[10:0];
          pbg_pkg::CFG_LAYER_HEIGHT:  lay_h_q  <= cfg_wdata_i[10:0];
          pbg_pkg::CFG_STEP_X:        step_x_q <= cfg_wdata_i[23:0];
          pbg_pkg::CFG_STEP_Y:        step_y_q <= cfg_wdata_i[23:0];
          pbg_pkg::CFG_CENTRE_OFFSET: off_q    <= cfg_wdata_i[7:0];
          pbg_pkg::CFG_CLIP_ENABLE:   clip_q   <= cfg_wdata_i[0];
        endcase
      end
      if (en) begin
        v_q[0] <= in_valid_i;
        v_q[1] <= v_q[0] && keep;
        for (int i = 2; i < NV; i++) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // zero divisors count as one
  logic [12:0] iw_e, ih_e;
  logic [10:0] lw_e, lh_e;
  logic        derived;
  assign iw_e    = (img_w_q == '0) ? 13'd1 : img_w_q;
  assign ih_e    = (img_h_q == '0) ? 13'd1 : img_h_q;
  assign lw_e    = (lay_w_q == '0) ? 11'd1 : lay_w_q;
  assign lh_e    = (lay_h_q == '0) ? 11'd1 : lay_h_q;
  assign derived = (step_x_q == '0) || (step_y_q == '0);

  // ---- stage 0: input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_i;
    end
  end

  // ---- stage 1: radicand for the shared root (mean square or aspect ratio)
  logic [pbg_pkg::SQRT_W-1:0] rad_q;
  sb_t                         sb1_q;
  logic [25:0]                 mnmx;
  logic [23:0]                 ar_e;
  assign mnmx = {13'd0, in_q.base_px} * {13'd0, in_q.outer_px};
  assign ar_e = (in_q.ratio_wh == '0) ? 24'd1 : in_q.ratio_wh;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_q.func == pbg_pkg::FUNC_MEAN_SQUARE) begin
        rad_q <= {mnmx, 32'd0};
      end else begin
        rad_q <= {2'b00, ar_e, 32'd0};
      end
      sb1_q <= '{col: in_q.cell_col, row: in_q.cell_row, func: in_q.func, mn: in_q.base_px};
    end
  end

  logic [ROOT_W-1:0] root;
  sb_t               sb10;

  pbg_sqrt #(.W(pbg_pkg::SQRT_W), .K(pbg_pkg::SQRT_K)) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (rad_q),
    .root_o(root)
  );

  pbg_dly #(.W($bits(sb_t)), .LEN(LS)) u_dly_sb (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (sb1_q),
    .q_o  (sb10)
  );

  // ---- stage m: width multiply and height numerator (min << 40, rounded by root/2)
  logic [MNR_W-1:0]          mnr_q;
  logic [pbg_pkg::TDIV_N-1:0] tnum_q;
  logic [ROOT_W-1:0]         root_q;
  sb_t                       sbm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mnr_q  <= {{ROOT_W{1'b0}}, sb10.mn} * {13'd0, root};
      tnum_q <= {1'b0, sb10.mn, 40'd0} + {25'd0, root[ROOT_W-1:1]};
      root_q <= root;
      sbm_q  <= sb10;
    end
  end

  logic [pbg_pkg::TDIV_N-1:0] tq;

  pbg_div #(.N(pbg_pkg::TDIV_N), .D(pbg_pkg::TDIV_D), .K(pbg_pkg::TDIV_K)) u_tdiv (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(tnum_q),
    .den_i(root_q),
    .quo_o(tq)
  );

  localparam int unsigned SIDE_W = $bits(sb_t) + ROOT_W + MNR_W;
  logic [SIDE_W-1:0] side_dly;
  sb_t               sbr;
  logic [ROOT_W-1:0] rootr;
  logic [MNR_W-1:0]  mnrr;

  pbg_dly #(.W(SIDE_W), .LEN(LT - 1)) u_dly_side (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({sbm_q, root_q, mnr_q}),
    .q_o  (side_dly)
  );
  assign {sbr, rootr, mnrr} = side_dly;

  // ---- stage p: centre products, aligned with the height quotient
  logic [41:0]       prodx_q, prody_q;
  logic [17:0]       kx_q, ky_q;
  logic [1:0]        func_p_q;
  logic [12:0]       mn_p_q;
  logic [ROOT_W-1:0] root_p_q;
  logic [MNR_W-1:0]  mnr_p_q;
  logic [17:0]       kx, ky;
  assign kx = {sbr.col, off_q};
  assign ky = {sbr.row, off_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      prodx_q  <= {24'd0, kx} * {18'd0, step_x_q};
      prody_q  <= {24'd0, ky} * {18'd0, step_y_q};
      kx_q     <= kx;
      ky_q     <= ky;
      func_p_q <= sbr.func;
      mn_p_q   <= sbr.mn;
      root_p_q <= rootr;
      mnr_p_q  <= mnrr;
    end
  end

  // ---- stage h: rounded numerators for the four normalizing divides
  logic [QW-1:0] cnum_x_q, cnum_y_q, hnum_x_q, hnum_y_q;
  logic [12:0]   cden_x_q, cden_y_q, hden_x_q, hden_y_q;
  logic [QW-1:0] hbase_x, hbase_y;

  always_comb begin
    case (func_p_q)
      pbg_pkg::FUNC_MEAN_SQUARE: begin
        hbase_x = {14'd0, root_p_q, 15'd0};
        hbase_y = {14'd0, root_p_q, 15'd0};
      end
      pbg_pkg::FUNC_ASPECT: begin
        hbase_x = {9'd0, mnr_p_q, 7'd0};
        hbase_y = {tq[43:0], 15'd0};
      end
      default: begin
        hbase_x = {15'd0, mn_p_q, 31'd0};
        hbase_y = {15'd0, mn_p_q, 31'd0};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (derived) begin
        cnum_x_q <= {17'd0, kx_q, 24'd0} + {49'd0, lw_e[10:1]};
        cnum_y_q <= {17'd0, ky_q, 24'd0} + {49'd0, lh_e[10:1]};
        cden_x_q <= {2'b00, lw_e};
        cden_y_q <= {2'b00, lh_e};
      end else begin
        cnum_x_q <= {1'b0, prodx_q, 16'd0} + {47'd0, iw_e[12:1]};
        cnum_y_q <= {1'b0, prody_q, 16'd0} + {47'd0, ih_e[12:1]};
        cden_x_q <= iw_e;
        cden_y_q <= ih_e;
      end
      hnum_x_q <= hbase_x + {47'd0, iw_e[12:1]};
      hnum_y_q <= hbase_y + {47'd0, ih_e[12:1]};
      hden_x_q <= iw_e;
      hden_y_q <= ih_e;
    end
  end

  logic [QW-1:0] cx, cy, hw, hh;

  pbg_div #(.N(QW), .D(pbg_pkg::DIV_D), .K(pbg_pkg::DIV_K)) u_div_cx (
    .clk_i(clk_i), .en_i(en), .num_i(cnum_x_q), .den_i(cden_x_q), .quo_o(cx)
  );
  pbg_div #(.N(QW), .D(pbg_pkg::DIV_D), .K(pbg_pkg::DIV_K)) u_div_cy (
    .clk_i(clk_i), .en_i(en), .num_i(cnum_y_q), .den_i(cden_y_q), .quo_o(cy)
  );
  pbg_div #(.N(QW), .D(pbg_pkg::DIV_D), .K(pbg_pkg::DIV_K)) u_div_hw (
    .clk_i(clk_i), .en_i(en), .num_i(hnum_x_q), .den_i(hden_x_q), .quo_o(hw)
  );
  pbg_div #(.N(QW), .D(pbg_pkg::DIV_D), .K(pbg_pkg::DIV_K)) u_div_hh (
    .clk_i(clk_i), .en_i(en), .num_i(hnum_y_q), .den_i(hden_y_q), .quo_o(hh)
  );

  // ---- stage f1: corners in q32
  logic signed [SUM_W-1:0] xmin_q, ymin_q, xmax_q, ymax_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xmin_q <= $signed({2'b00, cx}) - $signed({2'b00, hw});
      ymin_q <= $signed({2'b00, cy}) - $signed({2'b00, hh});
      xmax_q <= $signed({2'b00, cx}) + $signed({2'b00, hw});
      ymax_q <= $signed({2'b00, cy}) + $signed({2'b00, hh});
    end
  end

  // clip, round half away from zero, saturate; msb of the result is the saturation flag
  function automatic logic [COORD_W:0] finish(input logic signed [SUM_W-1:0] v,
                                              input logic clip);
    logic signed [SUM_W-1:0] c;
    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        rnd;
    logic                    sat;
    logic [COORD_W-1:0]      r;
    c = v;
    if (clip) begin
      if (v < 0) begin
        c = '0;
      end else if (v > ONE) begin
        c = ONE;
      end
    end
    neg = c[SUM_W-1];
    mag = neg ? SUM_W'(-c) : SUM_W'(c);
    rnd = (mag + RND_HALF) >> SH;
    if (!neg && rnd > POS_MAX) begin
      sat = 1'b1;
      r   = SAT_HI;
    end else if (neg && rnd > NEG_MAG) begin
      sat = 1'b1;
      r   = SAT_LO;
    end else begin
      sat = 1'b0;
      r   = neg ? COORD_W'(~rnd + SUM_W'(1)) : COORD_W'(rnd);
    end
    return {sat, r};
  endfunction

  // ---- output register
  pbg_pkg::out_t     out_q;
  logic [COORD_W:0]  f_xmin, f_ymin, f_xmax, f_ymax;
  assign f_xmin = finish(xmin_q, clip_q);
  assign f_ymin = finish(ymin_q, clip_q);
  assign f_xmax = finish(xmax_q, clip_q);
  assign f_ymax = finish(ymax_q, clip_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.box_xmin        <= f_xmin[COORD_W-1:0];
      out_q.box_ymin        <= f_ymin[COORD_W-1:0];
      out_q.box_xmax        <= f_xmax[COORD_W-1:0];
      out_q.box_ymax        <= f_ymax[COORD_W-1:0];
      out_q.range_saturated <= f_xmin[COORD_W] | f_ymin[COORD_W] |
                               f_xmax[COORD_W] | f_ymax[COORD_W];
    end
  end

  assign out_o = out_q;

  // a stall freezes every valid bit
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(v_q))
    else $error("valid line moved during a stall");

  // unused kind never passes the input stage
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && (in_q.func == pbg_pkg::FUNC_UNUSED) && in_ready_o |=> !v_q[1])
    else $error("unused prior kind entered the pipe");

  // the saturation flag comes only with a coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_q.range_saturated |->
      (out_q.box_xmin == SAT_HI || out_q.box_xmin == SAT_LO ||
       out_q.box_ymin == SAT_HI || out_q.box_ymin == SAT_LO ||
       out_q.box_xmax == SAT_HI || out_q.box_xmax == SAT_LO ||
       out_q.box_ymax == SAT_HI || out_q.box_ymax == SAT_LO))
    else $error("saturation flag without a saturated coordinate");

endmodule

### sim/prior_box_generator_top_test.sv
// self-checking testbench of the ssd prior box generator top level
`timescale 1ns / 100ps

module prior_box_generator_top_test;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned NORM_SHIFT  = 32;
  localparam int unsigned DRAIN_WAIT  = 64;    // beyond the pipe latency
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned WATCHDOG    = 4000;  // cycles with no beat on any channel
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 250;

  typedef struct {
    pbg_pkg::in_t item;
    bit           dropped;  // expected: no box comes out for this beat
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [pbg_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [pbg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  pbg_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pbg_pkg::out_t                  out_data;

  // shadow copy of the register file
  logic [12:0] img_w, img_h;
  logic [10:0] lay_w, lay_h;
  logic [23:0] pitch_x, pitch_y;
  logic [7:0]  ctr_offset;
  logic        clip_on;

  pbg_pkg::out_t box_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  prior_box_generator_top #(
    .OUT_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
    if (d == 0) d = 1;
    return (n + d / 2) / d;
  endfunction

  // integer square root, rounded to nearest
  function automatic longint unsigned sqrt_round(longint unsigned n);
    longint unsigned res, bitv, x;
    res = 0;
    bitv = 64'd1 << 62;
    x = n;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (x > res) res += 1;
    return res;
  endfunction

  // clip, round to the output fraction and saturate one corner
  function automatic logic [pbg_pkg::COORD_W-1:0] to_coord(longint v, inout bit sat);
    longint          one, hi, lo, r;
    longint unsigned mag;
    bit              neg;
    int unsigned     sh;
    one = longint'(1) << NORM_SHIFT;
    hi  = (longint'(1) << (pbg_pkg::COORD_W - 1)) - 1;
    lo  = -(longint'(1) << (pbg_pkg::COORD_W - 1));
    sh  = NORM_SHIFT - FRAC_BITS;
    neg = v < 0;
    if (clip_on) begin
      if (v < 0) v = 0;
      if (v > one) v = one;
      neg = 1'b0;
    end
    mag = neg ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    r = neg ? -longint'(mag) : longint'(mag);
    if (r > hi) begin
      r = hi;
      sat = 1'b1;
    end
    if (r < lo) begin
      r = lo;
      sat = 1'b1;
    end
    return r[pbg_pkg::COORD_W-1:0];
  endfunction

  // expected box of one beat; returns 0 when the beat yields nothing
  function automatic bit predict_box(pbg_pkg::in_t it, output pbg_pkg::out_t box);
    longint unsigned iw, ih, lw, lh, kx, ky, cx, cy, hw, hh, s, a, r, t;
    longint unsigned mn, mx;
    bit sat;
    box = '0;
    sat = 1'b0;
    if (it.func == pbg_pkg::FUNC_UNUSED) return 1'b0;
    if (it.func == pbg_pkg::FUNC_ASPECT && it.ratio_wh == pbg_pkg::AR_UNIT) return 1'b0;
    iw = img_w ? img_w : 1;
    ih = img_h ? img_h : 1;
    lw = lay_w ? lay_w : 1;
    lh = lay_h ? lay_h : 1;
    mn = it.base_px;
    mx = it.outer_px;
    kx = it.cell_col * 256 + ctr_offset;
    ky = it.cell_row * 256 + ctr_offset;
    // any zero pitch switches both axes to the derived step
    if (pitch_x == 0 || pitch_y == 0) begin
      cx = div_round(kx << 24, lw);
      cy = div_round(ky << 24, lh);
    end else begin
      cx = div_round((kx * pitch_x) << 16, iw);
      cy = div_round((ky * pitch_y) << 16, ih);
    end
    case (it.func)
      pbg_pkg::FUNC_MIN_SQUARE: begin
        hw = div_round(mn << 31, iw);
        hh = div_round(mn << 31, ih);
      end
      pbg_pkg::FUNC_MEAN_SQUARE: begin
        s  = sqrt_round((mn * mx) << 32);
        hw = div_round(s << 15, iw);
        hh = div_round(s << 15, ih);
      end
      default: begin
        a  = it.ratio_wh ? it.ratio_wh : 1;
        r  = sqrt_round(a << 32);
        t  = div_round(mn << 40, r);
        hw = div_round((mn * r) << 7, iw);
        hh = div_round(t << 15, ih);
      end
    endcase
    box.box_xmin = to_coord(longint'(cx) - longint'(hw), sat);
    box.box_ymin = to_coord(longint'(cy) - longint'(hh), sat);
    box.box_xmax = to_coord(longint'(cx) + longint'(hw), sat);
    box.box_ymax = to_coord(longint'(cy) + longint'(hh), sat);
    box.range_saturated = sat;
    return 1'b1;
  endfunction

  // one register write; the write strobe is held for exactly one clock edge
  task automatic write_reg(logic [pbg_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val[pbg_pkg::CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we    = 1'b0;
    case (idx)
      pbg_pkg::CFG_IMAGE_WIDTH:   img_w      = val[12:0];
      pbg_pkg::CFG_IMAGE_HEIGHT:  img_h      = val[12:0];
      pbg_pkg::CFG_LAYER_WIDTH:   lay_w      = val[10:0];
      pbg_pkg::CFG_LAYER_HEIGHT:  lay_h      = val[10:0];
      pbg_pkg::CFG_STEP_X:        pitch_x    = val[23:0];
      pbg_pkg::CFG_STEP_Y:        pitch_y    = val[23:0];
      pbg_pkg::CFG_CENTRE_OFFSET: ctr_offset = val[7:0];
      default:                    clip_on    = val[0];
    endcase
  endtask

  // offer one beat and hold it until accepted; the box is predicted on acceptance
  task automatic offer_cell(pbg_pkg::in_t it);
    pbg_pkg::out_t box;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    if (predict_box(it, box)) box_q.insert(box_q.size(), box);
    @(negedge clk_i);
  endtask

  // wait out every box plus any dropped beat still in the pipe
  task automatic drain_pipe();
    in_valid <= 1'b0;
    wait (box_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  function automatic pbg_pkg::in_t rand_cell();
    pbg_pkg::in_t it;
    it = '0;
    if ($urandom_range(3) == 0) begin
      // raw noise over the full field widths
      it = pbg_pkg::in_t'(72'({$urandom, $urandom, $urandom}));
    end else begin
      it.cell_col = 10'($urandom_range(lay_w > 1 ? lay_w - 1 : 0));
      it.cell_row = 10'($urandom_range(lay_h > 1 ? lay_h - 1 : 0));
      it.func     = ($urandom_range(19) == 0) ? pbg_pkg::FUNC_UNUSED : 2'($urandom_range(2));
      it.base_px  = 13'($urandom_range(1, img_w > 1 ? img_w : 1));
      it.outer_px = 13'($urandom_range(it.base_px, 4096));
      case ($urandom_range(5))
        0:       it.ratio_wh = 24'h020000;
        1:       it.ratio_wh = 24'h030000;
        2:       it.ratio_wh = 24'h008000;
        3:       it.ratio_wh = 24'h005555;
        4:       it.ratio_wh = ($urandom_range(15) == 0) ? pbg_pkg::AR_UNIT : 24'h010001;
        default: it.ratio_wh = 24'($urandom);
      endcase
    end
    return it;
  endfunction

  // register values for one phase: the first two take the extremes
  task automatic set_phase_regs(int p);
    case (p)
      0: begin
        write_reg(pbg_pkg::CFG_IMAGE_WIDTH, 0);
        write_reg(pbg_pkg::CFG_IMAGE_HEIGHT, 1);
        write_reg(pbg_pkg::CFG_LAYER_WIDTH, 0);
        write_reg(pbg_pkg::CFG_LAYER_HEIGHT, 1);
        write_reg(pbg_pkg::CFG_STEP_X, 0);
        write_reg(pbg_pkg::CFG_STEP_Y, 0);
        write_reg(pbg_pkg::CFG_CENTRE_OFFSET, 0);
        write_reg(pbg_pkg::CFG_CLIP_ENABLE, 0);
      end
      1: begin
        write_reg(pbg_pkg::CFG_IMAGE_WIDTH, 13'h1fff);
        write_reg(pbg_pkg::CFG_IMAGE_HEIGHT, 4096);
        write_reg(pbg_pkg::CFG_LAYER_WIDTH, 11'h7ff);
        write_reg(pbg_pkg::CFG_LAYER_HEIGHT, 1024);
        write_reg(pbg_pkg::CFG_STEP_X, 24'hffffff);
        write_reg(pbg_pkg::CFG_STEP_Y, 24'hffffff);
        write_reg(pbg_pkg::CFG_CENTRE_OFFSET, 255);
        write_reg(pbg_pkg::CFG_CLIP_ENABLE, 1);
      end
      default: begin
        write_reg(pbg_pkg::CFG_IMAGE_WIDTH,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(64, 1024));
        write_reg(pbg_pkg::CFG_IMAGE_HEIGHT,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(64, 1024));
        write_reg(pbg_pkg::CFG_LAYER_WIDTH,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 64));
        write_reg(pbg_pkg::CFG_LAYER_HEIGHT,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 64));
        // half the phases run with a configured pitch
        if (p % 2 == 0) begin
          write_reg(pbg_pkg::CFG_STEP_X,
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(256, 16384));
          write_reg(pbg_pkg::CFG_STEP_Y,
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(256, 16384));
        end else begin
          write_reg(pbg_pkg::CFG_STEP_X,
                    ($urandom_range(1) == 0) ? 0 : $urandom_range(256, 16384));
          write_reg(pbg_pkg::CFG_STEP_Y, 0);
        end
        write_reg(pbg_pkg::CFG_CENTRE_OFFSET, $urandom);
        write_reg(pbg_pkg::CFG_CLIP_ENABLE, $urandom);
      end
    endcase
  endtask

  // receiver: one of four stall patterns chosen at random, plus one long hold-off
  initial begin
    int unsigned hold_left, mode, cyc;
    hold_left = 0;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 128 == 0) mode = $urandom_range(3);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(1);
          2:       out_ready <= ($urandom_range(9) != 0);
          default: out_ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // box checker: every result beat against the oldest prediction
  always @(posedge clk_i) begin
    pbg_pkg::out_t exp_box;
    if (rst_ni && out_valid && out_ready) begin
      if (box_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected box beat %p", out_data);
      end else begin
        exp_box = box_q.pop_front();
        if (out_data.box_xmin !== exp_box.box_xmin || out_data.box_ymin !== exp_box.box_ymin ||
            out_data.box_xmax !== exp_box.box_xmax || out_data.box_ymax !== exp_box.box_ymax ||
            out_data.range_saturated !== exp_box.range_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("box mismatch: expected %p, got %p", exp_box, out_data);
        end
      end
    end
  end

  // watchdog: counts cycles with no beat on either data channel and no register write
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("** prior_box_generator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t      dir_tab[];
    int unsigned   burst_left;
    pbg_pkg::out_t dummy;

    // register defaults after reset
    img_w = 300; img_h = 300; lay_w = 38; lay_h = 38;
    pitch_x = 0; pitch_y = 0; ctr_offset = 128; clip_on = 1'b0;

    // cell_col, cell_row, func, base_px, outer_px, ratio_wh ; dropped
    dir_tab = '{
      '{'{10'd0,    10'd0,    pbg_pkg::FUNC_MIN_SQUARE,  13'd30,   13'd60,   24'd131072}, 1'b0},
      '{'{10'd1023, 10'd1023, pbg_pkg::FUNC_MIN_SQUARE,  13'd1,    13'd1,    24'd1},      1'b0},
      '{'{10'd0,    10'd1023, pbg_pkg::FUNC_MIN_SQUARE,  13'h1fff, 13'd0,    24'hffffff}, 1'b0},
      '{'{10'd37,   10'd0,    pbg_pkg::FUNC_MIN_SQUARE,  13'd0,    13'h1fff, 24'd0},      1'b0},
      '{'{10'd5,    10'd7,    pbg_pkg::FUNC_MEAN_SQUARE, 13'd30,   13'd60,   24'd65536},  1'b0},
      '{'{10'd0,    10'd0,    pbg_pkg::FUNC_MEAN_SQUARE, 13'd1,    13'd1,    24'd0},      1'b0},
      '{'{10'd1023, 10'd0,    pbg_pkg::FUNC_MEAN_SQUARE, 13'h1fff, 13'h1fff, 24'd0},      1'b0},
      '{'{10'd12,   10'd12,   pbg_pkg::FUNC_MEAN_SQUARE, 13'd4096, 13'd0,    24'd0},      1'b0},
      '{'{10'd3,    10'd4,    pbg_pkg::FUNC_ASPECT,      13'd30,   13'd0,    24'd131072}, 1'b0},
      '{'{10'd3,    10'd4,    pbg_pkg::FUNC_ASPECT,      13'd30,   13'd0,    24'd32768},  1'b0},
      '{'{10'd0,    10'd0,    pbg_pkg::FUNC_ASPECT,      13'd1,    13'd0,    24'd1},      1'b0},
      '{'{10'd0,    10'd0,    pbg_pkg::FUNC_ASPECT,      13'd100,  13'd0,    24'd0},      1'b0},
      '{'{10'd1023, 10'd1023, pbg_pkg::FUNC_ASPECT,      13'h1fff, 13'd0,    24'hffffff}, 1'b0},
      '{'{10'd20,   10'd20,   pbg_pkg::FUNC_ASPECT,      13'h1fff, 13'h1fff, 24'd1},      1'b0},
      // unit aspect ratio and the unused kind give no box
      '{'{10'd3,    10'd4,    pbg_pkg::FUNC_ASPECT,      13'd30,   13'd60,   24'd65536},  1'b1},
      '{'{10'd3,    10'd4,    pbg_pkg::FUNC_UNUSED,      13'd30,   13'd60,   24'd131072}, 1'b1},
      '{'{10'd1023, 10'd1023, pbg_pkg::FUNC_UNUSED,      13'h1fff, 13'h1fff, 24'hffffff}, 1'b1},
      '{'{10'd19,   10'd18,   pbg_pkg::FUNC_ASPECT,      13'd60,   13'd0,    24'd65537},  1'b0},
      '{'{10'd19,   10'd18,   pbg_pkg::FUNC_ASPECT,      13'd60,   13'd0,    24'd65535},  1'b0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at reset settings
    foreach (dir_tab[i]) begin
      if (predict_box(dir_tab[i].item, dummy) == dir_tab[i].dropped) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with the drop rule", i);
      end
      offer_cell(dir_tab[i].item);
    end
    drain_pipe();

    // random part, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      set_phase_regs(p);
      if (p == 2) hold_req = 1'b1;  // fill the pipe against a stalled output
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          // gap between bursts; some phases run back to back
          if (p % 3 != 1 && $urandom_range(1)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          // sender stops until the pipe is empty
          in_valid <= 1'b0;
          wait (box_q.size() == 0);
          @(negedge clk_i);
        end
        offer_cell(rand_cell());
        burst_left--;
      end
      drain_pipe();
    end

    if (mismatches == 0 && box_q.size() == 0) begin
      $display("** prior_box_generator_top: PASSED **");
    end else begin
      $display("** prior_box_generator_top: FAILED **");
    end
    $finish;
  end

endmodule

### prior_box_generator_top.f
sv/pbg_pkg.sv
sv/pbg_div.sv
sv/pbg_sqrt.sv
sv/pbg_dly.sv
sv/prior_box_generator_top.sv
sim/prior_box_generator_top_test.sv
